/* rtl/apfe_pkg.sv */
// apfe_pkg: shared types, constants and register indexes of the advertising
// packet filter. Used by every module of the block, depends on nothing.
`timescale 1ns / 1ps

package apfe_pkg;

  localparam int MAX_PACKET_DEF = 31;
  localparam int MFG_DEPTH      = 29;
  localparam int MFG_AW         = $clog2(MFG_DEPTH);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_NAME_PREFIX = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NAME_TYPE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MFG_TYPE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MFG_MIN_LEN = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MFG_SKIP    = 3'd4;

  localparam logic [23:0] NAME_PREFIX_RST = 24'h425953;
  localparam logic [7:0]  NAME_TYPE_RST   = 8'h09;
  localparam logic [7:0]  MFG_TYPE_RST    = 8'hFF;
  localparam logic [7:0]  MFG_MIN_LEN_RST = 8'd20;
  localparam logic [7:0]  MFG_SKIP_RST    = 8'd6;

  typedef struct packed {
    logic [23:0] name_prefix;
    logic [7:0]  name_type;
    logic [7:0]  mfg_type;
    logic [7:0]  mfg_min_len;
    logic [7:0]  mfg_skip;
  } cfg_t;

  // buffer write from the walker
  typedef struct packed {
    logic              en;
    logic [MFG_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  // drain request for an accepted packet: entries first .. stop-1
  typedef struct packed {
    logic              go;
    logic [MFG_AW-1:0] first;
    logic [MFG_AW-1:0] stop;
  } drain_req_t;

endpackage

/* rtl/apfe_in_if.sv */
// apfe_in_if: input item channel, one advertising byte per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface apfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] adv_byte;
  logic       last_byte;

  modport source (output valid, output adv_byte, output last_byte, input ready);
  modport sink (input valid, input adv_byte, input last_byte, output ready);
endinterface

/* rtl/apfe_out_if.sv */
// apfe_out_if: result item channel, one extracted payload byte per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface apfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [4:0] payload_index;
  logic       payload_last;

  modport source (output valid, output payload_byte, output payload_index,
                  output payload_last, input ready);
  modport sink (input valid, input payload_byte, input payload_index,
                input payload_last, output ready);
endinterface

/* rtl/adv_packet_filter_extract.sv */
// adv_packet_filter_extract: advertising packet filter and manufacturer
// payload extractor. Top level; depends on apfe_pkg, the two channel
// interfaces, apfe_walker and apfe_drain.
//
// Usage: advertising bytes enter on adv, one per item, last_byte on the
// final byte of a packet. Every byte is taken in the cycle it is offered,
// except after an accepted packet: then adv.ready stays low while the run
// is read from the 29-entry buffer memory, and longer while the receiver
// stalls. Results leave on payload; the buffer read data register is the
// output register, so the first result is offered once busy is set and
// the first read has loaded it. A stalled receiver simply holds the
// current result and pauses the read sequencer; a new packet may start
// while the last result of a run still waits. A rejected packet gives no
// result and no pause. Registers must be written on cfg_we with cfg_addr
// and cfg_wdata while idle; the block itself does not enforce it.
// Reset (rst, synchronous) returns the packet walk, the sequencer and the
// registers to their defaults; the buffer memory is not cleared, only
// entries written in the current packet are read.
`timescale 1ns / 1ps

module adv_packet_filter_extract #(
  parameter int MAX_PACKET = apfe_pkg::MAX_PACKET_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  apfe_in_if.sink                         adv,
  apfe_out_if.source                      payload,
  input  logic                            cfg_we,
  input  logic [apfe_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [apfe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import apfe_pkg::*;

  cfg_t       cfg;
  buf_wr_t    buf_wr;
  drain_req_t drain_req;
  logic       busy;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.name_prefix <= NAME_PREFIX_RST;
      cfg.name_type   <= NAME_TYPE_RST;
      cfg.mfg_type    <= MFG_TYPE_RST;
      cfg.mfg_min_len <= MFG_MIN_LEN_RST;
      cfg.mfg_skip    <= MFG_SKIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NAME_PREFIX: cfg.name_prefix <= cfg_wdata;
        REG_NAME_TYPE:   cfg.name_type   <= cfg_wdata[7:0];
        REG_MFG_TYPE:    cfg.mfg_type    <= cfg_wdata[7:0];
        REG_MFG_MIN_LEN: cfg.mfg_min_len <= cfg_wdata[7:0];
        REG_MFG_SKIP:    cfg.mfg_skip    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // buffer is busy being read out, hold off the next packet
  assign adv.ready = !busy;
  assign accept    = adv.valid && adv.ready;

  apfe_walker #(.MAX_PACKET(MAX_PACKET)) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .adv_byte  (adv.adv_byte),
    .last_byte (adv.last_byte),
    .buf_wr    (buf_wr),
    .drain_req (drain_req)
  );

  apfe_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .buf_wr    (buf_wr),
    .drain_req (drain_req),
    .busy      (busy),
    .payload   (payload)
  );

  a_go_blocks_input: assert property (@(posedge clk) disable iff (rst)
    drain_req.go |=> !adv.ready)
    else $error("input not held off after an accepted packet");

  a_no_write_while_read: assert property (@(posedge clk) disable iff (rst)
    !(buf_wr.en && busy))
    else $error("buffer written during read-out");

  a_run_range: assert property (@(posedge clk) disable iff (rst)
    drain_req.go |-> (drain_req.first < drain_req.stop) &&
                     (drain_req.stop <= MFG_AW'(MFG_DEPTH)))
    else $error("bad run bounds");

endmodule

/* rtl/apfe_walker.sv */
// apfe_walker: walks the length-type-payload structures of one packet,
// writes manufacturer payload bytes to the buffer and judges the packet.
// Depends on apfe_pkg.
`timescale 1ns / 1ps

module apfe_walker #(
  parameter int MAX_PACKET = apfe_pkg::MAX_PACKET_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  apfe_pkg::cfg_t      cfg,
  input  logic                accept,
  input  logic [7:0]          adv_byte,
  input  logic                last_byte,
  output apfe_pkg::buf_wr_t   buf_wr,
  output apfe_pkg::drain_req_t drain_req
);
  import apfe_pkg::*;

  localparam int PW = $clog2(MAX_PACKET + 2);
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_PACKET);
  localparam logic [PW-1:0] POS_SAT   = PW'(MAX_PACKET + 1);

  typedef enum logic [1:0] {PH_LEN, PH_TYPE, PH_DATA} phase_t;

  phase_t      phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]  remaining, remaining_next;
  logic [1:0]  kind, kind_next;
  logic        stopped, stopped_next;
  logic        name_seen, name_seen_next;
  logic        name_match, name_match_next;
  logic [1:0]  name_count, name_count_next;
  logic        mfg_seen, mfg_seen_next;
  logic [7:0]  mfg_length, mfg_length_next;
  logic [7:0]  want;
  logic [1:0]  done_kind;
  logic        done;
  logic        wr_en;
  logic        pass;
  logic [MFG_AW-1:0] stored;

  always_comb begin
    unique case (name_count)
      2'd0:    want = cfg.name_prefix[23:16];
      2'd1:    want = cfg.name_prefix[15:8];
      default: want = cfg.name_prefix[7:0];
    endcase
  end

  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    kind_next       = kind;
    name_seen_next  = name_seen;
    name_match_next = name_match;
    name_count_next = name_count;
    mfg_seen_next   = mfg_seen;
    mfg_length_next = mfg_length;
    done            = 1'b0;
    done_kind       = 2'b00;
    wr_en           = 1'b0;
    stopped_next    = stopped || (pos >= POS_LIMIT);
    pos_next        = (pos == POS_SAT) ? pos : pos + PW'(1);

    if (!stopped_next) begin
      unique case (phase)
        PH_LEN: begin
          if (adv_byte == 8'd0) begin
            // a zero length on the final byte is just padding
            if (!last_byte) stopped_next = 1'b1;
          end else begin
            remaining_next = adv_byte;
            phase_next     = PH_TYPE;
          end
        end
        PH_TYPE: begin
          remaining_next = remaining - 8'd1;
          kind_next      = 2'b00;
          if (adv_byte == cfg.name_type && !name_seen) begin
            kind_next[0]    = 1'b1;
            name_count_next = 2'd0;
            name_match_next = 1'b1;
          end
          if (adv_byte == cfg.mfg_type && !mfg_seen) begin
            kind_next[1]    = 1'b1;
            mfg_length_next = 8'd0;
          end
          if (remaining_next == 8'd0) begin
            done      = 1'b1;
            done_kind = kind_next;
          end else begin
            phase_next = PH_DATA;
          end
        end
        default: begin
          if (kind[0]) begin
            if (name_count != 2'd3) begin
              if (adv_byte != want) name_match_next = 1'b0;
              name_count_next = name_count + 2'd1;
            end
          end
          if (kind[1]) begin
            wr_en = (mfg_length < 8'(MFG_DEPTH));
            if (mfg_length != 8'hFF) mfg_length_next = mfg_length + 8'd1;
          end
          remaining_next = remaining - 8'd1;
          if (remaining_next == 8'd0) begin
            done      = 1'b1;
            done_kind = kind;
          end
        end
      endcase
    end

    if (done) begin
      if (done_kind[0]) name_seen_next = 1'b1;
      if (done_kind[1]) mfg_seen_next = 1'b1;
      kind_next  = 2'b00;
      phase_next = PH_LEN;
    end
  end

  // verdict on the state as it stands after the final byte
  always_comb begin
    stored = (mfg_length_next < 8'(MFG_DEPTH)) ? mfg_length_next[MFG_AW-1:0]
                                               : MFG_AW'(MFG_DEPTH);
    pass = (pos_next <= POS_LIMIT) && name_seen_next && name_match_next &&
           (name_count_next == 2'd3) && mfg_seen_next &&
           (mfg_length_next >= cfg.mfg_min_len);
  end

  assign buf_wr.en      = accept && wr_en;
  assign buf_wr.addr    = mfg_length[MFG_AW-1:0];
  assign buf_wr.data    = adv_byte;
  assign drain_req.go    = accept && last_byte && pass && (cfg.mfg_skip < 8'(stored));
  assign drain_req.first = cfg.mfg_skip[MFG_AW-1:0];
  assign drain_req.stop  = stored;

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase      <= PH_LEN;
      pos        <= '0;
      remaining  <= '0;
      kind       <= '0;
      stopped    <= 1'b0;
      name_seen  <= 1'b0;
      name_match <= 1'b0;
      name_count <= '0;
      mfg_seen   <= 1'b0;
      mfg_length <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      pos        <= pos_next;
      remaining  <= remaining_next;
      kind       <= kind_next;
      stopped    <= stopped_next;
      name_seen  <= name_seen_next;
      name_match <= name_match_next;
      name_count <= name_count_next;
      mfg_seen   <= mfg_seen_next;
      mfg_length <= mfg_length_next;
    end
  end

endmodule

/* rtl/apfe_drain.sv */
// apfe_drain: manufacturer payload buffer memory and the read sequencer
// that streams an accepted run out. Depends on apfe_pkg and apfe_out_if.
`timescale 1ns / 1ps

module apfe_drain (
  input  logic                 clk,
  input  logic                 rst,
  input  apfe_pkg::buf_wr_t    buf_wr,
  input  apfe_pkg::drain_req_t drain_req,
  output logic                 busy,
  apfe_out_if.source           payload
);
  import apfe_pkg::*;

  logic [7:0]        mem [MFG_DEPTH];
  logic [MFG_AW-1:0] rd_addr;
  logic [MFG_AW-1:0] stop;
  logic [4:0]        run_index;
  logic [7:0]        rd_data;
  logic              out_valid;
  logic [4:0]        out_index;
  logic              out_last;
  logic              issue;
  logic              final_read;

  // read data register doubles as the output register
  assign issue      = busy && (!out_valid || payload.ready);
  assign final_read = (rd_addr + MFG_AW'(1)) == stop;

  always_ff @(posedge clk) begin
    if (buf_wr.en) mem[buf_wr.addr] <= buf_wr.data;
  end

  always_ff @(posedge clk) begin
    if (issue) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      rd_addr   <= '0;
      stop      <= '0;
      run_index <= '0;
      out_index <= '0;
      out_last  <= 1'b0;
    end else begin
      if (drain_req.go) begin
        busy      <= 1'b1;
        rd_addr   <= drain_req.first;
        stop      <= drain_req.stop;
        run_index <= '0;
      end else if (issue) begin
        rd_addr   <= rd_addr + MFG_AW'(1);
        run_index <= run_index + 5'd1;
        if (final_read) busy <= 1'b0;
      end
      if (issue) begin
        out_valid <= 1'b1;
        out_index <= run_index;
        out_last  <= final_read;
      end else if (payload.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign payload.valid         = out_valid;
  assign payload.payload_byte  = rd_data;
  assign payload.payload_index = out_index;
  assign payload.payload_last  = out_last;

endmodule
